// ===== hw/rtl/irac_pkg.sv =====
// Shared types and constants of the IR air-conditioner frame transmitter.
// Request and response structs, sequencer phase codes, register indexes and code tables.
// No dependencies.
package irac_pkg;

   localparam int unsigned FRAME_BITS = 64;
   localparam int unsigned SEG_BITS   = 15;
   localparam int unsigned CSR_IDX_BITS = 3;

   typedef struct packed {
      logic       req_type;
      logic       power_on;
      logic [2:0] ac_mode;
      logic [1:0] fan_speed;
      logic [7:0] temp_c;
   } irac_req_type;

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic frame_end;
      logic rejected;
   } irac_rsp_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HMARK  = 3'd1,
      PH_HSPACE = 3'd2,
      PH_BMARK  = 3'd3,
      PH_BSPACE = 3'd4,
      PH_FMARK  = 3'd5,
      PH_GAP    = 3'd6
   } irac_phase_type;

   // request kinds
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_BASE_FRAME   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEADER_MARK  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_HEADER_SPACE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BIT_MARK     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_ONE_SPACE    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_ZERO_SPACE   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAP          = 3'd6;

   // register reset values
   localparam logic [FRAME_BITS-1:0] RST_BASE_FRAME   = 64'h0;
   localparam logic [SEG_BITS-1:0]   RST_HEADER_MARK  = 15'd8984;
   localparam logic [SEG_BITS-1:0]   RST_HEADER_SPACE = 15'd4200;
   localparam logic [SEG_BITS-1:0]   RST_BIT_MARK     = 15'd572;
   localparam logic [SEG_BITS-1:0]   RST_ONE_SPACE    = 15'd1558;
   localparam logic [SEG_BITS-1:0]   RST_ZERO_SPACE   = 15'd510;
   localparam logic [SEG_BITS-1:0]   RST_GAP          = 15'd30000;

   // on-air mode codes
   localparam logic [2:0] MODE_CODE_COOL = 3'd0;
   localparam logic [2:0] MODE_CODE_DRY  = 3'd1;
   localparam logic [2:0] MODE_CODE_FAN  = 3'd2;
   localparam logic [2:0] MODE_CODE_AUTO = 3'd4;

   // request mode -> on-air mode; heat and unused codes go out as auto
   localparam logic [2:0] MODE_CODE [8] = '{
      MODE_CODE_AUTO, MODE_CODE_COOL, MODE_CODE_DRY, MODE_CODE_FAN,
      MODE_CODE_AUTO, MODE_CODE_AUTO, MODE_CODE_AUTO, MODE_CODE_AUTO
   };

   // request fan speed -> on-air fan code
   localparam logic [1:0] FAN_CODE [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

   localparam logic [7:0] TEMP_MIN    = 8'd18;
   localparam logic [7:0] TEMP_MAX    = 8'd32;
   localparam logic [7:0] TEMP_OFFSET = 8'd17;
   localparam logic [4:0] TEMP_CODE_NONE = 5'd0;
   localparam logic [4:0] TEMP_CODE_FAN  = 5'b00110;

endpackage

// ===== hw/rtl/irac_frame_build.sv =====
// Frame assembly: patches temperature, fan, power and mode into the base frame
// and appends the byte checksum. Depends on irac_pkg.
module irac_frame_build (
   input  logic [irac_pkg::FRAME_BITS-1:0] base_frame,
   input  irac_pkg::irac_req_type          req,
   output logic [irac_pkg::FRAME_BITS-1:0] frame
);

   logic [2:0] mode_code;
   logic [1:0] fan_code;
   logic [7:0] temp_clamped;
   logic [7:0] temp_diff;
   logic [4:0] temp_code;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic [7:0] check_sum;
   logic [irac_pkg::FRAME_BITS-1:0] body;

   assign mode_code = irac_pkg::MODE_CODE[req.ac_mode];
   assign fan_code  = irac_pkg::FAN_CODE[req.fan_speed];

   always_comb begin
      if (req.temp_c < irac_pkg::TEMP_MIN) begin
         temp_clamped = irac_pkg::TEMP_MIN;
      end else if (req.temp_c > irac_pkg::TEMP_MAX) begin
         temp_clamped = irac_pkg::TEMP_MAX;
      end else begin
         temp_clamped = req.temp_c;
      end
   end

   assign temp_diff = temp_clamped - irac_pkg::TEMP_OFFSET;

   always_comb begin
      if (mode_code == irac_pkg::MODE_CODE_AUTO || mode_code == irac_pkg::MODE_CODE_DRY) begin
         temp_code = irac_pkg::TEMP_CODE_NONE;
      end else if (mode_code == irac_pkg::MODE_CODE_FAN) begin
         temp_code = irac_pkg::TEMP_CODE_FAN;
      end else begin
         temp_code = temp_diff[4:0];
      end
   end

   assign byte1 = {1'b0, fan_code, temp_code};
   assign byte2 = {4'b0000, mode_code, req.power_on};

   assign body = {8'h00, base_frame[55:24], byte2, byte1, base_frame[7:0]};

   // checksum over bytes 0..6, modulo 256
   always_comb begin
      check_sum = 8'h00;
      for (int k = 0; k < 7; k++) begin
         check_sum = check_sum + body[k*8 +: 8];
      end
   end

   assign frame = {check_sum, body[55:0]};

endmodule

// ===== hw/rtl/ir_ac_frame_transmitter.sv =====
// Depends on irac_pkg and irac_frame_build. Accepted requests' responses are registered.
// Throughput: one request per cycle unless a held response stalls; each tick request
// advances the envelope by one tick. A send request takes no tick; the whole frame
// plays out over the following tick requests. Reset (synchronous, active high)
// restores the register defaults, idles the sequencer and empties the output register.
module ir_ac_frame_transmitter #(
   parameter int unsigned DURATION_BITS = 15
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  irac_pkg::irac_req_type                     req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output irac_pkg::irac_rsp_type                     rsp_data,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [irac_pkg::CSR_IDX_BITS-1:0]          csr_index,
   input  logic [irac_pkg::FRAME_BITS-1:0]            csr_wdata
);

   localparam int unsigned SB = irac_pkg::SEG_BITS;

   // configuration registers
   logic [irac_pkg::FRAME_BITS-1:0] base_frame_ff;
   logic [SB-1:0] header_mark_ff;
   logic [SB-1:0] header_space_ff;
   logic [SB-1:0] bit_mark_ff;
   logic [SB-1:0] one_space_ff;
   logic [SB-1:0] zero_space_ff;
   logic [SB-1:0] gap_ff;

   // sequencer state
   logic [irac_pkg::FRAME_BITS-1:0] shift_frame_ff, shift_frame_in;
   irac_pkg::irac_phase_type        phase_ff, phase_in;
   logic [5:0]                      bit_index_ff, bit_index_in;
   logic [DURATION_BITS-1:0]        tick_count_ff, tick_count_in;

   // output register
   logic                   rsp_valid_ff;
   irac_pkg::irac_rsp_type rsp_data_ff;
   irac_pkg::irac_rsp_type rsp_in;

   logic                            req_accept;
   logic                            active;
   logic                            is_mark;
   logic [SB-1:0]                   seg_len;
   logic [DURATION_BITS-1:0]        tick_next;
   logic                            seg_done;
   logic [irac_pkg::FRAME_BITS-1:0] new_frame;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   irac_frame_build u_build (
      .base_frame (base_frame_ff),
      .req        (req_data),
      .frame      (new_frame)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frame_ff   <= irac_pkg::RST_BASE_FRAME;
         header_mark_ff  <= irac_pkg::RST_HEADER_MARK;
         header_space_ff <= irac_pkg::RST_HEADER_SPACE;
         bit_mark_ff     <= irac_pkg::RST_BIT_MARK;
         one_space_ff    <= irac_pkg::RST_ONE_SPACE;
         zero_space_ff   <= irac_pkg::RST_ZERO_SPACE;
         gap_ff          <= irac_pkg::RST_GAP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            irac_pkg::REG_BASE_FRAME:   base_frame_ff   <= csr_wdata;
            irac_pkg::REG_HEADER_MARK:  header_mark_ff  <= csr_wdata[SB-1:0];
            irac_pkg::REG_HEADER_SPACE: header_space_ff <= csr_wdata[SB-1:0];
            irac_pkg::REG_BIT_MARK:     bit_mark_ff     <= csr_wdata[SB-1:0];
            irac_pkg::REG_ONE_SPACE:    one_space_ff    <= csr_wdata[SB-1:0];
            irac_pkg::REG_ZERO_SPACE:   zero_space_ff   <= csr_wdata[SB-1:0];
            irac_pkg::REG_GAP:          gap_ff          <= csr_wdata[SB-1:0];
            default: ;
         endcase
      end
   end

   // current segment: length, level, and whether a frame is on air
   always_comb begin
      unique case (phase_ff)
         irac_pkg::PH_HMARK: begin
            seg_len = header_mark_ff;  is_mark = 1'b1; active = 1'b1;
         end
         irac_pkg::PH_HSPACE: begin
            seg_len = header_space_ff; is_mark = 1'b0; active = 1'b1;
         end
         irac_pkg::PH_BMARK: begin
            seg_len = bit_mark_ff;     is_mark = 1'b1; active = 1'b1;
         end
         irac_pkg::PH_BSPACE: begin
            seg_len = shift_frame_ff[0] ? one_space_ff : zero_space_ff;
            is_mark = 1'b0; active = 1'b1;
         end
         irac_pkg::PH_FMARK: begin
            seg_len = bit_mark_ff;     is_mark = 1'b1; active = 1'b1;
         end
         irac_pkg::PH_GAP: begin
            seg_len = gap_ff;          is_mark = 1'b0; active = 1'b1;
         end
         default: begin
            seg_len = gap_ff;          is_mark = 1'b0; active = 1'b0;
         end
      endcase
   end

   assign tick_next = tick_count_ff + 1'b1;
   // a zero-length segment still lasts one tick
   assign seg_done  = (tick_next >= DURATION_BITS'(seg_len)) || (tick_next == '0);

   // next state
   always_comb begin
      shift_frame_in = shift_frame_ff;
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      tick_count_in  = tick_count_ff;
      if (req_data.req_type == irac_pkg::REQ_SEND) begin
         if (!active) begin
            shift_frame_in = new_frame;
            phase_in       = irac_pkg::PH_HMARK;
            bit_index_in   = '0;
            tick_count_in  = '0;
         end
      end else if (active) begin
         if (seg_done) begin
            tick_count_in = '0;
            unique case (phase_ff)
               irac_pkg::PH_HMARK:  phase_in = irac_pkg::PH_HSPACE;
               irac_pkg::PH_HSPACE: phase_in = irac_pkg::PH_BMARK;
               irac_pkg::PH_BMARK:  phase_in = irac_pkg::PH_BSPACE;
               irac_pkg::PH_BSPACE: begin
                  shift_frame_in = {1'b0, shift_frame_ff[irac_pkg::FRAME_BITS-1:1]};
                  if (&bit_index_ff) begin
                     bit_index_in = '0;
                     phase_in     = irac_pkg::PH_FMARK;
                  end else begin
                     bit_index_in = bit_index_ff + 1'b1;
                     phase_in     = irac_pkg::PH_BMARK;
                  end
               end
               irac_pkg::PH_FMARK:  phase_in = irac_pkg::PH_GAP;
               default:             phase_in = irac_pkg::PH_IDLE;
            endcase
         end else begin
            tick_count_in = tick_next;
         end
      end else begin
         phase_in = irac_pkg::PH_IDLE;
      end
   end

   // response for the request being accepted
   always_comb begin
      rsp_in = '0;
      if (req_data.req_type == irac_pkg::REQ_SEND) begin
         rsp_in.busy_res = 1'b1;
         rsp_in.rejected = active;
      end else if (active) begin
         rsp_in.busy_res  = 1'b1;
         rsp_in.led_on    = is_mark;
         rsp_in.frame_end = seg_done && (phase_ff == irac_pkg::PH_GAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_frame_ff <= '0;
         phase_ff       <= irac_pkg::PH_IDLE;
         bit_index_ff   <= '0;
         tick_count_ff  <= '0;
      end else if (req_accept) begin
         shift_frame_ff <= shift_frame_in;
         phase_ff       <= phase_in;
         bit_index_ff   <= bit_index_in;
         tick_count_ff  <= tick_count_in;
      end
   end

   // hold the response until it is taken; refill on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_in.frame_end) |=> (phase_ff == irac_pkg::PH_IDLE))
      else $error("frame end did not return the sequencer to idle");

   a_reject_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_in.rejected) |=>
         (shift_frame_ff == $past(shift_frame_ff) && phase_ff == $past(phase_ff)))
      else $error("rejected send request disturbed the frame in progress");

   a_bit_index_phase: assert property (@(posedge clock) disable iff (reset)
      (bit_index_ff != '0) |->
         (phase_ff == irac_pkg::PH_BMARK || phase_ff == irac_pkg::PH_BSPACE))
      else $error("bit index nonzero outside the data bits");
`endif

endmodule

// ===== dv/tb_ir_ac_frame_transmitter.sv =====
// Self-checking bench for the IR air-conditioner frame transmitter: directed table, then random
// frames over two register settings; responses checked against the table or an envelope predictor.
// Depends on irac_pkg and the ir_ac_frame_transmitter RTL.
module tb_ir_ac_frame_transmitter;

   // request-side mode and fan speed codes
   localparam logic [2:0] MODE_AUTO = 3'd0;
   localparam logic [2:0] MODE_COOL = 3'd1;
   localparam logic [2:0] MODE_DRY  = 3'd2;
   localparam logic [2:0] MODE_FAN  = 3'd3;
   localparam logic [2:0] MODE_HEAT = 3'd4;
   localparam logic [1:0] FAN_AUTO  = 2'd0;
   localparam logic [1:0] FAN_LOW   = 2'd1;
   localparam logic [1:0] FAN_MED   = 2'd2;
   localparam logic [1:0] FAN_HIGH  = 2'd3;
   // on-air fan codes
   localparam logic [1:0] AIR_FAN_AUTO = 2'd0;
   localparam logic [1:0] AIR_FAN_HIGH = 2'd1;
   localparam logic [1:0] AIR_FAN_MED  = 2'd2;
   localparam logic [1:0] AIR_FAN_LOW  = 2'd3;
   localparam logic [irac_pkg::CSR_IDX_BITS-1:0] REG_SPARE = 3'd7;
   localparam int unsigned STALL_LIMIT = 2000;

   typedef struct {
      bit                     cfg_before;
      irac_pkg::irac_req_type req;
      bit                     typed;
      irac_pkg::irac_rsp_type want;
      bit                     play_out;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   irac_pkg::irac_req_type            req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   irac_pkg::irac_rsp_type            rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [irac_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [irac_pkg::FRAME_BITS-1:0]   csr_wdata = '0;

   // predictor copy of the registers and sequencer
   logic [irac_pkg::FRAME_BITS-1:0] cfg_base   = 64'h0;
   logic [irac_pkg::SEG_BITS-1:0]   cfg_hmark  = 15'd8984;
   logic [irac_pkg::SEG_BITS-1:0]   cfg_hspace = 15'd4200;
   logic [irac_pkg::SEG_BITS-1:0]   cfg_bmark  = 15'd572;
   logic [irac_pkg::SEG_BITS-1:0]   cfg_one    = 15'd1558;
   logic [irac_pkg::SEG_BITS-1:0]   cfg_zero   = 15'd510;
   logic [irac_pkg::SEG_BITS-1:0]   cfg_gap    = 15'd30000;
   logic [irac_pkg::FRAME_BITS-1:0] frame_sr   = '0;
   irac_pkg::irac_phase_type        seq_phase  = irac_pkg::PH_IDLE;
   logic [5:0]                      bit_pos    = '0;
   logic [irac_pkg::SEG_BITS-1:0]   dwell      = '0;

   irac_pkg::irac_rsp_type due_levels[$];
   bit                     due_typed = 1'b0;
   irac_pkg::irac_rsp_type due_typed_rsp = '0;

   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned req_count = 0;
   int unsigned rsp_count = 0;
   int unsigned frames_done = 0;
   int unsigned rejects_seen = 0;
   int unsigned write_count = 0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;
   logic        calm = 1'b0;

   ir_ac_frame_transmitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic irac_pkg::irac_req_type make_req(logic kind, logic pwr, logic [2:0] mode,
                                                       logic [1:0] fan, logic [7:0] temp);
      irac_pkg::irac_req_type r;
      r.req_type  = kind;
      r.power_on  = pwr;
      r.ac_mode   = mode;
      r.fan_speed = fan;
      r.temp_c    = temp;
      return r;
   endfunction

   function automatic irac_pkg::irac_req_type rand_tick();
      return make_req(irac_pkg::REQ_TICK, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
   endfunction

   function automatic irac_pkg::irac_req_type rand_send();
      logic [7:0] t;
      // half the temperatures sit near the clamp limits
      t = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(15, 35));
      return make_req(irac_pkg::REQ_SEND, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      2'($urandom_range(0, 3)), t);
   endfunction

   function automatic plan_row_type plan_row(bit cfg, irac_pkg::irac_req_type q, bit typed,
                                             logic [3:0] lvl, bit play);
      plan_row_type p;
      p.cfg_before = cfg;
      p.req        = q;
      p.typed      = typed;
      p.want       = irac_pkg::irac_rsp_type'(lvl);
      p.play_out   = play;
      return p;
   endfunction

   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 75) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [irac_pkg::SEG_BITS-1:0] short_len();
      return ($urandom_range(0, 9) < 8) ? irac_pkg::SEG_BITS'($urandom_range(0, 2))
                                        : irac_pkg::SEG_BITS'($urandom_range(3, 6));
   endfunction

   // fill the upper data bits with noise; segment registers keep the low bits only
   function automatic logic [irac_pkg::FRAME_BITS-1:0] stray_bits(
      logic [irac_pkg::SEG_BITS-1:0] v);
      logic [irac_pkg::FRAME_BITS-1:0] w;
      w = {$urandom, $urandom};
      w[irac_pkg::SEG_BITS-1:0] = v;
      return w;
   endfunction

   function automatic logic [irac_pkg::FRAME_BITS-1:0] compose_frame(
      irac_pkg::irac_req_type r);
      logic [irac_pkg::FRAME_BITS-1:0] f;
      logic [2:0]                      air_mode;
      logic [1:0]                      air_fan;
      logic [7:0]                      t;
      logic [4:0]                      tcode;
      logic [7:0]                      sum;
      case (r.ac_mode)
         MODE_COOL: air_mode = irac_pkg::MODE_CODE_COOL;
         MODE_DRY:  air_mode = irac_pkg::MODE_CODE_DRY;
         MODE_FAN:  air_mode = irac_pkg::MODE_CODE_FAN;
         default:   air_mode = irac_pkg::MODE_CODE_AUTO;
      endcase
      case (r.fan_speed)
         FAN_AUTO: air_fan = AIR_FAN_AUTO;
         FAN_LOW:  air_fan = AIR_FAN_LOW;
         FAN_MED:  air_fan = AIR_FAN_MED;
         default:  air_fan = AIR_FAN_HIGH;
      endcase
      t = r.temp_c;
      if (t < 8'd18) t = 8'd18;
      if (t > 8'd32) t = 8'd32;
      if (air_mode == irac_pkg::MODE_CODE_AUTO || air_mode == irac_pkg::MODE_CODE_DRY)
         tcode = 5'd0;
      else if (air_mode == irac_pkg::MODE_CODE_FAN) tcode = 5'd6;
      else tcode = 5'(t - 8'd17);
      f = cfg_base;
      f[15:8]  = {1'b0, air_fan, tcode};
      f[23:16] = {4'b0000, air_mode, r.power_on};
      sum = '0;
      for (int k = 0; k < 7; k++) sum = sum + f[k*8 +: 8];
      f[63:56] = sum;
      return f;
   endfunction

   // advance the envelope by one request and return the levels it produces
   task step_envelope(input irac_pkg::irac_req_type r, output irac_pkg::irac_rsp_type o);
      logic [irac_pkg::SEG_BITS-1:0] seg;
      logic [irac_pkg::SEG_BITS-1:0] nxt;
      logic                          active;
      o = '0;
      active = (seq_phase >= irac_pkg::PH_HMARK) && (seq_phase <= irac_pkg::PH_GAP);
      if (r.req_type == irac_pkg::REQ_SEND) begin
         o.busy_res = 1'b1;
         if (active) begin
            o.rejected = 1'b1;
            rejects_seen++;
         end else begin
            frame_sr  = compose_frame(r);
            seq_phase = irac_pkg::PH_HMARK;
            bit_pos   = '0;
            dwell     = '0;
         end
      end else if (active) begin
         case (seq_phase)
            irac_pkg::PH_HMARK:  seg = cfg_hmark;
            irac_pkg::PH_HSPACE: seg = cfg_hspace;
            irac_pkg::PH_BMARK, irac_pkg::PH_FMARK: seg = cfg_bmark;
            irac_pkg::PH_BSPACE: seg = frame_sr[0] ? cfg_one : cfg_zero;
            default:             seg = cfg_gap;
         endcase
         nxt = dwell + 15'd1;
         o.busy_res = 1'b1;
         o.led_on = (seq_phase == irac_pkg::PH_HMARK) || (seq_phase == irac_pkg::PH_BMARK) ||
                    (seq_phase == irac_pkg::PH_FMARK);
         // a zero length ends the segment after one tick, like a length of one
         if (nxt >= seg || nxt == '0) begin
            dwell = '0;
            case (seq_phase)
               irac_pkg::PH_HMARK:  seq_phase = irac_pkg::PH_HSPACE;
               irac_pkg::PH_HSPACE: seq_phase = irac_pkg::PH_BMARK;
               irac_pkg::PH_BMARK:  seq_phase = irac_pkg::PH_BSPACE;
               irac_pkg::PH_BSPACE: begin
                  frame_sr = frame_sr >> 1;
                  if (bit_pos == 6'd63) begin
                     bit_pos   = '0;
                     seq_phase = irac_pkg::PH_FMARK;
                  end else begin
                     bit_pos   = bit_pos + 6'd1;
                     seq_phase = irac_pkg::PH_BMARK;
                  end
               end
               irac_pkg::PH_FMARK:  seq_phase = irac_pkg::PH_GAP;
               default: begin
                  o.frame_end = 1'b1;
                  seq_phase   = irac_pkg::PH_IDLE;
                  frames_done++;
               end
            endcase
         end else begin
            dwell = nxt;
         end
      end
   endtask

   task compare_level(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endtask

   // entered at a falling edge; returns at the falling edge after acceptance
   task issue_request(input irac_pkg::irac_req_type r, input bit typed,
                      input irac_pkg::irac_rsp_type want);
      int unsigned gap;
      gap = pick_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      due_typed     = typed;
      due_typed_rsp = want;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task write_reg(input logic [irac_pkg::CSR_IDX_BITS-1:0] idx,
                  input logic [irac_pkg::FRAME_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         irac_pkg::REG_BASE_FRAME:   cfg_base   = data;
         irac_pkg::REG_HEADER_MARK:  cfg_hmark  = data[irac_pkg::SEG_BITS-1:0];
         irac_pkg::REG_HEADER_SPACE: cfg_hspace = data[irac_pkg::SEG_BITS-1:0];
         irac_pkg::REG_BIT_MARK:     cfg_bmark  = data[irac_pkg::SEG_BITS-1:0];
         irac_pkg::REG_ONE_SPACE:    cfg_one    = data[irac_pkg::SEG_BITS-1:0];
         irac_pkg::REG_ZERO_SPACE:   cfg_zero   = data[irac_pkg::SEG_BITS-1:0];
         irac_pkg::REG_GAP:          cfg_gap    = data[irac_pkg::SEG_BITS-1:0];
         default: ;
      endcase
      write_count++;
      @(negedge clock);
   endtask

   task configure(input logic [irac_pkg::FRAME_BITS-1:0] base,
                  input logic [irac_pkg::SEG_BITS-1:0] hm,
                  input logic [irac_pkg::SEG_BITS-1:0] hs, input logic [irac_pkg::SEG_BITS-1:0] bm,
                  input logic [irac_pkg::SEG_BITS-1:0] os, input logic [irac_pkg::SEG_BITS-1:0] zs,
                  input logic [irac_pkg::SEG_BITS-1:0] gp);
      write_reg(irac_pkg::REG_BASE_FRAME, base);
      write_reg(irac_pkg::REG_HEADER_MARK, stray_bits(hm));
      write_reg(irac_pkg::REG_HEADER_SPACE, stray_bits(hs));
      write_reg(irac_pkg::REG_BIT_MARK, stray_bits(bm));
      write_reg(irac_pkg::REG_ONE_SPACE, stray_bits(os));
      write_reg(irac_pkg::REG_ZERO_SPACE, stray_bits(zs));
      write_reg(irac_pkg::REG_GAP, stray_bits(gp));
      // unmapped index: must leave every register alone
      write_reg(REG_SPARE, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // drop valid and wait until every response is back
   task settle();
      req_valid <= 1'b0;
      while (due_levels.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // well-formed frames with random content; stray sends while busy and idle ticks as noise
   task run_random_phase(input int unsigned budget);
      int unsigned issued;
      issued = 0;
      while (issued < budget || seq_phase != irac_pkg::PH_IDLE) begin
         if (seq_phase == irac_pkg::PH_IDLE) begin
            if ($urandom_range(0, 4) == 0) begin
               issue_request(rand_tick(), 1'b0, '0);
            end else begin
               issue_request(rand_send(), 1'b0, '0);
               issued++;
            end
         end else if ($urandom_range(0, 59) == 0) begin
            issue_request(rand_send(), 1'b0, '0);
         end else begin
            issue_request(rand_tick(), 1'b0, '0);
            issued++;
         end
      end
   endtask

   always @(posedge clock) begin
      irac_pkg::irac_rsp_type forecast;
      irac_pkg::irac_rsp_type want;
      bit                     moved;
      moved = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            step_envelope(req_data, forecast);
            if (due_typed) forecast = due_typed_rsp;
            due_levels.push_back(forecast);
            req_count++;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            rsp_count++;
            if (due_levels.size() == 0) begin
               $error("response %b with no request outstanding", rsp_data);
               fail_count++;
            end else begin
               want = due_levels.pop_front();
               compare_level("led_on", want.led_on, rsp_data.led_on);
               compare_level("busy_res", want.busy_res, rsp_data.busy_res);
               compare_level("frame_end", want.frame_end, rsp_data.frame_end);
               compare_level("rejected", want.rejected, rsp_data.rejected);
            end
         end
         if (csr_valid && csr_ready) moved = 1'b1;
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // alternate calm stretches with no idling on either side
   always @(negedge clock) begin
      if (calm_left == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(100, 600);
      end else begin
         calm_left--;
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left = calm ? 200 : $urandom_range(0, 10);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = pick_idle();
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("[ir_ac_frame_transmitter] ERROR");
      $finish;
   end

   initial begin
      plan_row_type plan[$];
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset register values: idle tick, send, send while busy, first tick of the default frame
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_TICK, 1'b0, MODE_AUTO, FAN_AUTO, 8'd0),
                              1'b1, 4'b0000, 1'b0));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_SEND, 1'b1, MODE_COOL, FAN_HIGH, 8'd24),
                              1'b1, 4'b0100, 1'b0));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_SEND, 1'b0, MODE_HEAT, FAN_AUTO, 8'd255),
                              1'b1, 4'b0101, 1'b0));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_TICK, 1'b1, MODE_FAN, FAN_LOW, 8'd255),
                              1'b1, 4'b1100, 1'b0));
      // shorten the segments while that frame is on air, then play it out; from here on
      // single-tick segments, a two-tick one space, and bytes 0 and 6 of the template all ones
      plan.push_back(plan_row(1'b1, make_req(irac_pkg::REQ_TICK, 1'b0, MODE_AUTO, FAN_AUTO, 8'd0),
                              1'b0, 4'b0000, 1'b1));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_SEND, 1'b1, MODE_COOL, FAN_LOW, 8'd17),
                              1'b0, 4'b0000, 1'b1));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_SEND, 1'b0, MODE_FAN, FAN_MED, 8'd255),
                              1'b0, 4'b0000, 1'b1));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_TICK, 1'b1, 3'd7, FAN_HIGH, 8'd255),
                              1'b1, 4'b0000, 1'b0));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_SEND, 1'b1, MODE_COOL, FAN_HIGH, 8'd33),
                              1'b0, 4'b0000, 1'b0));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_SEND, 1'b1, MODE_DRY, FAN_HIGH, 8'd30),
                              1'b1, 4'b0101, 1'b0));
      plan.push_back(plan_row(1'b0, make_req(irac_pkg::REQ_TICK, 1'b0, MODE_AUTO, FAN_AUTO, 8'd0),
                              1'b1, 4'b1100, 1'b1));

      foreach (plan[i]) begin
         if (plan[i].cfg_before) begin
            settle();
            configure(64'h00FF_0000_0000_00FF, '0, '0, '0, 15'd2, '0, '0);
         end
         issue_request(plan[i].req, plan[i].typed, plan[i].want);
         if (plan[i].play_out)
            while (seq_phase != irac_pkg::PH_IDLE) issue_request(rand_tick(), 1'b0, '0);
      end

      settle();
      configure({$urandom, $urandom}, short_len(), short_len(), short_len(),
                short_len(), short_len(), short_len());
      run_random_phase(1);
      // longer header mark and gap, one frame with stray sends along the way
      settle();
      configure({$urandom, $urandom}, 15'd24, 15'd0, 15'd0, 15'd1, 15'd0, 15'd24);
      run_random_phase(1);

      settle();
      repeat (8) @(negedge clock);
      $display("Checked %0d responses to %0d requests: %0d frames played out, %0d sends refused,",
               rsp_count, req_count, frames_done, rejects_seen);
      $display("%0d register writes over directed, random and long-segment settings.",
               write_count);
      if (fail_count == 0) begin
         $display("[ir_ac_frame_transmitter] OK");
      end else begin
         $display("[ir_ac_frame_transmitter] ERROR");
      end
      $finish;
   end

endmodule
